[rtl/mbb_pkg.sv]
// Shared types and constants for the MSB-first bit buffer.
// Holds field widths, request codes, controller states and the command and
// status structs. Depends on nothing.
`default_nettype none

package mbb_pkg;

    localparam int REQ_W         = 2;
    localparam int WBITS_W       = 8;
    localparam int CNT_W         = 4;
    localparam int LEN_W         = 11;
    localparam int RD_W          = 8;
    localparam int USED_W        = 11;
    localparam int BYTE_W        = 8;
    localparam int BUF_BYTES_DEF = 1024;

    localparam logic [LEN_W-1:0] LEN_RESET = 11'd1024;
    localparam logic [CNT_W-1:0] BITS_PER_BYTE = 4'd8;

    typedef enum logic [REQ_W-1:0] {
        REQ_REWIND = 2'd0,
        REQ_PUT    = 2'd1,
        REQ_GET    = 2'd2,
        REQ_USED   = 2'd3
    } req_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ACC,
        ST_SECOND,
        ST_HOLD
    } state_t;

    typedef struct packed {
        logic accept;
        logic mem_wr0;
        logic mem_rd1;
        logic mem_wr1;
        logic cap0;
        logic cap1;
        logic load_out;
    } cmd_t;

    typedef struct packed {
        logic op_put;
        logic op_get;
        logic straddle;
        logic out_free;
    } status_t;

endpackage

`default_nettype wire

[rtl/mbb_interfaces.sv]
// Valid/ready channel interfaces for request words and result words.
// Depends on mbb_pkg for the field widths.
`default_nettype none

interface mbb_req_if;
    logic                        valid;
    logic                        ready;
    logic [mbb_pkg::REQ_W-1:0]   req_type;
    logic [mbb_pkg::WBITS_W-1:0] write_bits;
    logic [mbb_pkg::CNT_W-1:0]   bit_count;

    modport source  (output valid, req_type, write_bits, bit_count, input ready);
    modport sink    (input valid, req_type, write_bits, bit_count, output ready);
    modport monitor (input valid, ready, req_type, write_bits, bit_count);
endinterface

interface mbb_rsp_if;
    logic                       valid;
    logic                       ready;
    logic [mbb_pkg::RD_W-1:0]   read_bits;
    logic [mbb_pkg::USED_W-1:0] used_bytes;
    logic                       overrun;

    modport source  (output valid, read_bits, used_bytes, overrun, input ready);
    modport sink    (input valid, read_bits, used_bytes, overrun, output ready);
    modport monitor (input valid, ready, read_bits, used_bytes, overrun);
endinterface

`default_nettype wire

[rtl/mbb_ctrl.sv]
// Controller state machine of the bit buffer: sequences the byte store
// accesses of one request and hands the result to the output register.
// Depends on mbb_pkg.
`default_nettype none

module mbb_ctrl (
    input  wire              clk,
    input  wire              rst_n,
    input  wire              in_valid,
    output logic             in_ready,
    input  mbb_pkg::status_t status,
    output mbb_pkg::cmd_t    cmd
);
    import mbb_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        cmd        = '0;
        in_ready   = 1'b0;
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = ST_ACC;
                end
            end
            ST_ACC:
            begin
                // The first byte has been read; merge a put or take the get bits.
                cmd.cap0    = 1'b1;
                cmd.mem_wr0 = status.op_put;
                if (status.straddle && (status.op_put || status.op_get))
                begin
                    cmd.mem_rd1 = status.op_get;
                    state_next  = ST_SECOND;
                end
                else if (status.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
                else
                begin
                    state_next = ST_HOLD;
                end
            end
            ST_SECOND:
            begin
                cmd.cap1    = 1'b1;
                cmd.mem_wr1 = status.op_put;
                if (status.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
                else
                begin
                    state_next = ST_HOLD;
                end
            end
            ST_HOLD:
            begin
                if (status.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
        endcase
    end

endmodule

`default_nettype wire

[rtl/mbb_datapath.sv]
// Datapath of the bit buffer: bit cursor, length register, single-port byte
// store with registered read, bit merge and extract logic, output register.
// Depends on mbb_pkg.
`default_nettype none

module mbb_datapath #(
    parameter int BUF_BYTES = mbb_pkg::BUF_BYTES_DEF
) (
    input  wire                          clk,
    input  wire                          rst_n,
    input  wire                          cfg_wr_en,
    input  wire  [mbb_pkg::LEN_W-1:0]    cfg_wr_data,
    input  wire  [mbb_pkg::REQ_W-1:0]    req_type,
    input  wire  [mbb_pkg::WBITS_W-1:0]  write_bits,
    input  wire  [mbb_pkg::CNT_W-1:0]    bit_count,
    input  mbb_pkg::cmd_t                cmd,
    output mbb_pkg::status_t             status,
    input  wire                          out_ready,
    output logic                         out_valid,
    output logic [mbb_pkg::RD_W-1:0]     out_read_bits,
    output logic [mbb_pkg::USED_W-1:0]   out_used_bytes,
    output logic                         out_overrun
);
    import mbb_pkg::*;

    localparam int ADDR_W = (BUF_BYTES > 1) ? $clog2(BUF_BYTES) : 1;
    localparam int PW     = $clog2(BUF_BYTES + 1);
    localparam int CW     = (PW + 2 > LEN_W + 1) ? PW + 2 : LEN_W + 1;

    // Cursor and length.
    logic [PW-1:0]    pos_cur_reg;
    logic [CNT_W-1:0] fr_cur_reg;
    logic [LEN_W-1:0] buffer_len_reg;

    // Request latched at accept.
    logic [ADDR_W-1:0]  acc_pos_reg;
    logic [CNT_W-1:0]   acc_fr_reg;
    logic [CNT_W-1:0]   n_reg;
    logic [BYTE_W-1:0]  v_reg;
    logic               op_put_reg;
    logic               op_get_reg;
    logic               straddle_reg;
    logic [USED_W-1:0]  used_reg;
    logic               ovr_reg;
    logic [RD_W-1:0]    rd_reg;

    // Byte store.
    logic [BYTE_W-1:0] mem [BUF_BYTES];
    logic [BYTE_W-1:0] rdata_reg;
    logic [ADDR_W-1:0] mem_addr;
    logic [BYTE_W-1:0] mem_wdata;
    logic              mem_we;

    logic              out_valid_reg;
    logic [RD_W-1:0]   out_rd_reg;
    logic [USED_W-1:0] out_used_reg;
    logic              out_ovr_reg;

    // Accept-time cursor arithmetic.
    logic [CNT_W-1:0]  n_sat;
    logic              lazy;
    logic [CW-1:0]     pos_eff;
    logic [CNT_W-1:0]  fr_eff;
    logic              straddle;
    logic [CW-1:0]     last;
    logic [CW-1:0]     eff_len;
    logic              is_access;
    logic              refused;
    logic              taken;
    logic [PW-1:0]     pos_new;
    logic [CNT_W-1:0]  fr_new;
    logic [CW-1:0]     used_new;
    logic [BYTE_W-1:0] wmask;

    // Merge and extract.
    logic [CNT_W-1:0]  fr2;
    logic [CNT_W-1:0]  over;
    logic [BYTE_W-1:0] keep;
    logic [BYTE_W-1:0] low_part;
    logic [BYTE_W-1:0] byte0;
    logic [BYTE_W-1:0] byte1;
    logic [BYTE_W-1:0] aligned0;
    logic [RD_W-1:0]   part0;
    logic [RD_W-1:0]   part1;
    logic [RD_W-1:0]   rd_out;

    always_comb
    begin
        n_sat     = (bit_count > BITS_PER_BYTE) ? BITS_PER_BYTE : bit_count;
        lazy      = (fr_cur_reg == '0);
        pos_eff   = CW'(pos_cur_reg) + CW'(lazy);
        fr_eff    = lazy ? BITS_PER_BYTE : fr_cur_reg;
        straddle  = (n_sat > fr_eff);
        last      = pos_eff + CW'(straddle);
        eff_len   = (CW'(buffer_len_reg) > CW'(BUF_BYTES)) ? CW'(BUF_BYTES)
                                                           : CW'(buffer_len_reg);
        is_access = ((req_t'(req_type) == REQ_PUT) || (req_t'(req_type) == REQ_GET))
                    && (n_sat != '0);
        refused   = is_access && (last >= eff_len);
        taken     = is_access && !refused;
        wmask     = BYTE_W'((9'd1 << n_sat) - 9'd1);

        if (req_t'(req_type) == REQ_REWIND)
        begin
            pos_new = '0;
            fr_new  = BITS_PER_BYTE;
        end
        else if (taken)
        begin
            pos_new = last[PW-1:0];
            fr_new  = straddle ? (fr_eff + BITS_PER_BYTE - n_sat) : (fr_eff - n_sat);
        end
        else
        begin
            pos_new = pos_cur_reg;
            fr_new  = fr_cur_reg;
        end
        used_new = CW'(pos_new) + CW'(fr_new != BITS_PER_BYTE);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_cur_reg    <= '0;
            fr_cur_reg     <= BITS_PER_BYTE;
            buffer_len_reg <= LEN_RESET;
            op_put_reg     <= 1'b0;
            op_get_reg     <= 1'b0;
            straddle_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                buffer_len_reg <= cfg_wr_data;
            end
            if (cmd.accept)
            begin
                pos_cur_reg  <= pos_new;
                fr_cur_reg   <= fr_new;
                op_put_reg   <= taken && (req_t'(req_type) == REQ_PUT);
                op_get_reg   <= taken && (req_t'(req_type) == REQ_GET);
                straddle_reg <= straddle;
            end
            if (cmd.load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            acc_pos_reg <= pos_eff[ADDR_W-1:0];
            acc_fr_reg  <= fr_eff;
            n_reg       <= n_sat;
            v_reg       <= write_bits & wmask;
            used_reg    <= used_new[USED_W-1:0];
            ovr_reg     <= refused;
        end
        if (cmd.cap0 || cmd.cap1)
        begin
            rd_reg <= rd_out;
        end
        if (cmd.load_out)
        begin
            out_rd_reg   <= rd_out;
            out_used_reg <= used_reg;
            out_ovr_reg  <= ovr_reg;
        end
    end

    // Bit merge for puts and bit extract for gets, from the byte just read.
    always_comb
    begin
        fr2      = acc_fr_reg + BITS_PER_BYTE - n_reg;
        over     = n_reg - acc_fr_reg;
        keep     = 8'hFF << acc_fr_reg;
        if (straddle_reg)
        begin
            low_part = v_reg >> over;
        end
        else
        begin
            low_part = v_reg << (acc_fr_reg - n_reg);
        end
        byte0    = (rdata_reg & keep) | low_part;
        byte1    = v_reg << fr2;
        aligned0 = rdata_reg << (BITS_PER_BYTE - acc_fr_reg);
        part0    = op_get_reg ? (aligned0 >> (BITS_PER_BYTE - n_reg)) : '0;
        part1    = op_get_reg ? (rdata_reg >> fr2) : '0;
        priority if (cmd.cap0)
        begin
            rd_out = part0;
        end
        else if (cmd.cap1)
        begin
            rd_out = rd_reg | part1;
        end
        else
        begin
            rd_out = rd_reg;
        end
    end

    // Store port: the first byte is read at accept, the second one after it.
    always_comb
    begin
        if (cmd.mem_rd1 || cmd.mem_wr1)
        begin
            mem_addr = acc_pos_reg + ADDR_W'(1);
        end
        else if (cmd.accept)
        begin
            mem_addr = pos_eff[ADDR_W-1:0];
        end
        else
        begin
            mem_addr = acc_pos_reg;
        end
        mem_we    = cmd.mem_wr0 || cmd.mem_wr1;
        mem_wdata = cmd.mem_wr1 ? byte1 : byte0;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_addr] <= mem_wdata;
        end
        rdata_reg <= mem[mem_addr];
    end

    assign status.op_put   = op_put_reg;
    assign status.op_get   = op_get_reg;
    assign status.straddle = straddle_reg;
    assign status.out_free = !out_valid_reg || out_ready;

    assign out_valid      = out_valid_reg;
    assign out_read_bits  = out_rd_reg;
    assign out_used_bytes = out_used_reg;
    assign out_overrun    = out_ovr_reg;

endmodule

`default_nettype wire

[rtl/msb_first_bit_buffer.sv]
// Top level of the MSB-first bit buffer: joins the controller and datapath
// to the request and result channels. Depends on mbb_pkg, mbb_interfaces,
// mbb_ctrl and mbb_datapath.
//
// Usage: each request word on the request channel either rewinds the bit
// cursor, puts 1 to 8 bits MSB-first, gets 1 to 8 bits MSB-first, or asks
// for the number of bytes used. Every request word yields exactly one result
// word on the result channel, in order. A put or get that would touch a byte
// at or beyond the programmed buffer length is refused and flagged overrun.
// The user must write the length register through cfg_wr_en/cfg_wr_data
// only while idle; the block does not enforce this.
//
// Timing: a request is accepted with the first store read, then merged or
// extracted; a straddling put or get then handles the second byte, as the
// store has one port. Last, the output loads and the next request is taken.
// A result waiting in the output register does not block the next request;
// only when that request completes while the receiver still stalls does the
// block hold and stop accepting. Reset clears the cursor to byte 0, sets the
// length to 1024 and empties the output; the byte store is not cleared.
`default_nettype none

module msb_first_bit_buffer #(
    parameter int BUF_BYTES = mbb_pkg::BUF_BYTES_DEF
) (
    input wire                       clk,
    input wire                       rst_n,
    input wire                       cfg_wr_en,
    input wire [mbb_pkg::LEN_W-1:0]  cfg_wr_data,
    mbb_req_if.sink                  request,
    mbb_rsp_if.source                result
);
    import mbb_pkg::*;

    cmd_t    cmd;
    status_t status;

    // The controller only sequences; all storage lives in the datapath.
    mbb_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (request.valid),
        .in_ready (request.ready),
        .status   (status),
        .cmd      (cmd)
    );

    mbb_datapath #(
        .BUF_BYTES (BUF_BYTES)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .req_type       (request.req_type),
        .write_bits     (request.write_bits),
        .bit_count      (request.bit_count),
        .cmd            (cmd),
        .status         (status),
        .out_ready      (result.ready),
        .out_valid      (result.valid),
        .out_read_bits  (result.read_bits),
        .out_used_bytes (result.used_bytes),
        .out_overrun    (result.overrun)
    );

endmodule

`default_nettype wire

[rtl/mbb_checker.sv]
// Port-level assertions for the MSB-first bit buffer and the bind that
// attaches them to the top level. Depends on mbb_pkg and mbb_interfaces.
`default_nettype none

module mbb_checker #(
    parameter int BUF_BYTES = mbb_pkg::BUF_BYTES_DEF
) (
    input wire                        clk,
    input wire                        rst_n,
    input wire                        request_valid,
    input wire                        request_ready,
    input wire                        result_valid,
    input wire                        result_ready,
    input wire [mbb_pkg::RD_W-1:0]    result_read_bits,
    input wire [mbb_pkg::USED_W-1:0]  result_used_bytes,
    input wire                        result_overrun
);

    // One request word is handled at a time, so ready drops after a handshake.
    a_one_word_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        request_valid && request_ready |=> !request_ready)
        else $error("request ready stayed high after an accepted word");

    // A refused access never returns data.
    a_overrun_no_data: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_overrun |-> result_read_bits == '0)
        else $error("overrun result carries read data");

    // The cursor never runs past the store.
    a_used_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> int'(result_used_bytes) <= BUF_BYTES)
        else $error("used byte count exceeds the store size");

    // A stalled result word holds still.
    a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(result_read_bits)
            && $stable(result_used_bytes) && $stable(result_overrun))
        else $error("result word changed while stalled");

endmodule

bind msb_first_bit_buffer mbb_checker #(
    .BUF_BYTES (BUF_BYTES)
) u_mbb_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .request_valid     (request.valid),
    .request_ready     (request.ready),
    .result_valid      (result.valid),
    .result_ready      (result.ready),
    .result_read_bits  (result.read_bits),
    .result_used_bytes (result.used_bytes),
    .result_overrun    (result.overrun)
);

`default_nettype wire

[bench/msb_first_bit_buffer_tb.sv]
// Self-checking testbench for the MSB-first bit buffer top level.
// Drives request words, predicts each result word and checks it on arrival.
// Depends on mbb_pkg, mbb_interfaces and the msb_first_bit_buffer RTL.
`default_nettype none

module msb_first_bit_buffer_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import mbb_pkg::*;

    // Size of the byte store in the instance under test (default parameter).
    localparam int unsigned STORE_BYTES = BUF_BYTES_DEF;

    // One expected result word, field for field as the result channel shows it.
    typedef struct packed {
        logic [RD_W-1:0]   read_bits;
        logic [USED_W-1:0] used_bytes;
        logic              overrun;
    } result_word_t;

    // Stall patterns of the result receiver.
    typedef enum logic [1:0] {
        SINK_OPEN,
        SINK_RANDOM,
        SINK_RUNS,
        SINK_PERIODIC
    } sink_mode_t;

    logic               clk;
    logic               rst_n;
    logic               cfg_wr_en;
    logic [LEN_W-1:0]   cfg_wr_data;

    mbb_req_if req_ch ();
    mbb_rsp_if rsp_ch ();

    msb_first_bit_buffer dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .request     (req_ch),
        .result      (rsp_ch)
    );

    // Predicted state of the block: the byte store image, which entries have
    // been written, the bit cursor and the programmed length register.
    bit [BYTE_W-1:0]    store_image   [STORE_BYTES];
    bit                 store_written [STORE_BYTES];
    bit [LEN_W-1:0]     cursor_byte;
    bit [CNT_W-1:0]     cursor_free;
    bit [LEN_W-1:0]     length_reg;

    // Results predicted but not yet seen, oldest first.
    result_word_t       awaited_results [$];

    int unsigned        error_count;
    int unsigned        results_seen;
    int unsigned        words_sent;

    // Sender pacing: the sender works in bursts and idles between them.
    int unsigned        burst_left;
    bit                 idle_enabled;
    bit                 sender_valid;
    bit                 last_overrun;

    // Receiver pacing state.
    sink_mode_t         sink_mode;
    int unsigned        sink_cycle;
    int unsigned        sink_run;
    bit                 sink_ready;

    always #5 clk = ~clk;

    // The run ends here if the block stops answering. The slowest correct
    // run is well under a millisecond, so this leaves a wide margin.
    initial
    begin
        #5_000_000;
        $display("Some tests failed");
        $finish;
    end

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------

    // Number of usable bytes: the length register saturated at the store size.
    function automatic int unsigned active_len();
        int unsigned len;
        len = length_reg;
        return (len > STORE_BYTES) ? STORE_BYTES : len;
    endfunction

    // Bit counts above eight behave as eight.
    function automatic int unsigned clamp_count(input logic [CNT_W-1:0] cnt);
        return (cnt > 8) ? 8 : cnt;
    endfunction

    // Applies one request word to the predicted state and returns the result
    // word the block must produce for it.
    function automatic result_word_t apply_request(input req_t req,
                                                   input logic [WBITS_W-1:0] wbits,
                                                   input logic [CNT_W-1:0] cnt);
        result_word_t res;
        int unsigned  n;
        int unsigned  pos;
        int unsigned  fr;
        int unsigned  last;
        int unsigned  over;
        int unsigned  v;
        int unsigned  keep;
        int unsigned  cur;
        int unsigned  r;

        res = '0;
        n = clamp_count(cnt);
        case (req)
            REQ_REWIND:
            begin
                cursor_byte = '0;
                cursor_free = 4'd8;
            end
            REQ_PUT, REQ_GET:
            begin
                if (n != 0)
                begin
                    pos = cursor_byte;
                    fr = cursor_free;
                    // The step to the next byte happens only now, when the
                    // current byte is used up.
                    if (fr == 0 || fr > 8)
                    begin
                        pos++;
                        fr = 8;
                    end
                    last = (n > fr) ? pos + 1 : pos;
                    if (last >= active_len())
                    begin
                        // Refused: nothing changes, not even the lazy step.
                        res.overrun = 1'b1;
                    end
                    else if (req == REQ_PUT)
                    begin
                        v = wbits & ((1 << n) - 1);
                        keep = (32'hFF << fr) & 32'hFF;
                        cur = store_image[pos] & keep;
                        if (n > fr)
                        begin
                            over = n - fr;
                            store_image[pos] = BYTE_W'(cur | (v >> over));
                            store_written[pos] = 1'b1;
                            pos++;
                            fr = 8 - over;
                            store_image[pos] = BYTE_W'((v << fr) & 32'hFF);
                            store_written[pos] = 1'b1;
                        end
                        else
                        begin
                            store_image[pos] = BYTE_W'(cur | ((v << (fr - n)) & 32'hFF));
                            store_written[pos] = 1'b1;
                            fr -= n;
                        end
                        cursor_byte = LEN_W'(pos);
                        cursor_free = CNT_W'(fr);
                    end
                    else
                    begin
                        r = ((store_image[pos] << (8 - fr)) & 32'hFF) >> (8 - n);
                        if (n > fr)
                        begin
                            pos++;
                            fr += 8 - n;
                            r |= store_image[pos] >> fr;
                        end
                        else
                        begin
                            fr -= n;
                        end
                        res.read_bits = RD_W'(r);
                        cursor_byte = LEN_W'(pos);
                        cursor_free = CNT_W'(fr);
                    end
                end
            end
            default:
            begin
            end
        endcase
        res.used_bytes = USED_W'(cursor_byte + ((cursor_free != 4'd8) ? 1 : 0));
        return res;
    endfunction

    // True when a get of this count would be accepted and read a byte that
    // no put has written yet. Such a get is never sent.
    function automatic bit get_touches_unwritten(input logic [CNT_W-1:0] cnt);
        int unsigned n;
        int unsigned pos;
        int unsigned fr;

        n = clamp_count(cnt);
        if (n == 0)
            return 1'b0;
        pos = cursor_byte;
        fr = cursor_free;
        if (fr == 0 || fr > 8)
        begin
            pos++;
            fr = 8;
        end
        if (((n > fr) ? pos + 1 : pos) >= active_len())
            return 1'b0;
        if (!store_written[pos])
            return 1'b1;
        return (n > fr) && !store_written[pos + 1];
    endfunction

    // ------------------------------------------------------------------
    // Request side
    // ------------------------------------------------------------------

    // Offers one request word and waits for the handshake. The expectation is
    // computed at the edge that accepts the word, so the predicted state always
    // matches the order in which the block sees the words. After the word the
    // sender may end its burst and idle before offering the next word.
    task automatic send_word(input req_t req, input logic [WBITS_W-1:0] wbits,
                             input logic [CNT_W-1:0] cnt);
        result_word_t predicted;
        int unsigned  gap;

        req_ch.valid      <= 1'b1;
        req_ch.req_type   <= req;
        req_ch.write_bits <= wbits;
        req_ch.bit_count  <= cnt;
        sender_valid = 1'b1;
        do
            @(posedge clk);
        while (!req_ch.ready);
        predicted = apply_request(req, wbits, cnt);
        last_overrun = predicted.overrun;
        awaited_results.push_back(predicted);
        words_sent++;
        if (burst_left > 0)
            burst_left--;
        if (burst_left == 0)
        begin
            gap = 0;
            if (idle_enabled && $urandom_range(0, 3) != 0)
                gap = $urandom_range(1, 8);
            if (gap != 0)
            begin
                req_ch.valid <= 1'b0;
                sender_valid = 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 16);
        end
    endtask

    // Random traffic goes through here so that no accepted get ever reads a
    // store entry that was never written; such a get becomes a used query.
    task automatic send_safe(input req_t req, input logic [WBITS_W-1:0] wbits,
                             input logic [CNT_W-1:0] cnt);
        if (req == REQ_GET && get_touches_unwritten(cnt))
            send_word(REQ_USED, wbits, cnt);
        else
            send_word(req, wbits, cnt);
    endtask

    // Lowers valid and holds the sender until every predicted result is back.
    task automatic wait_for_results();
        if (sender_valid)
        begin
            req_ch.valid <= 1'b0;
            sender_valid = 1'b0;
        end
        while (awaited_results.size() != 0)
            @(posedge clk);
    endtask

    // The length register is written only with the block idle.
    task automatic set_buffer_len(input logic [LEN_W-1:0] len);
        wait_for_results();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= len;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        length_reg = len;
    endtask

    // Mostly legal counts, now and then the full four-bit range.
    function automatic logic [CNT_W-1:0] pick_count();
        if ($urandom_range(0, 4) != 0)
            return CNT_W'($urandom_range(1, 8));
        return CNT_W'($urandom_range(0, 15));
    endfunction

    function automatic req_t pick_request();
        return req_t'($urandom_range(0, 3));
    endfunction

    // ------------------------------------------------------------------
    // Result side: stall pattern and checking
    // ------------------------------------------------------------------

    task automatic report_mismatch(input string field, input logic [USED_W-1:0] got,
                                   input logic [USED_W-1:0] want);
        $display("MISMATCH at result word %0d, %s: got 0x%0h, expected 0x%0h",
                 results_seen, field, got, want);
        error_count++;
    endtask

    // Every accepted result word is checked against the oldest expectation.
    // The ready pattern is drawn at random from four characters: always ready,
    // coin flips, long runs of stall, or a fixed periodic pattern.
    always @(posedge clk)
    begin : result_sink
        result_word_t want;

        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            if (awaited_results.size() == 0)
            begin
                report_mismatch("word with nothing expected", rsp_ch.used_bytes, '0);
            end
            else
            begin
                want = awaited_results.pop_front();
                if (rsp_ch.read_bits !== want.read_bits)
                    report_mismatch("read_bits", USED_W'(rsp_ch.read_bits),
                                    USED_W'(want.read_bits));
                if (rsp_ch.used_bytes !== want.used_bytes)
                    report_mismatch("used_bytes", rsp_ch.used_bytes, want.used_bytes);
                if (rsp_ch.overrun !== want.overrun)
                    report_mismatch("overrun", USED_W'(rsp_ch.overrun),
                                    USED_W'(want.overrun));
            end
            results_seen++;
        end

        sink_cycle++;
        if (sink_cycle % 256 == 0)
            sink_mode = sink_mode_t'($urandom_range(0, 3));
        case (sink_mode)
            SINK_OPEN:
                sink_ready = 1'b1;
            SINK_RANDOM:
                sink_ready = 1'($urandom_range(0, 1));
            SINK_RUNS:
            begin
                if (sink_run == 0)
                begin
                    sink_ready = !sink_ready;
                    sink_run = sink_ready ? $urandom_range(1, 6) : $urandom_range(1, 20);
                end
                else
                begin
                    sink_run--;
                end
            end
            default:
                sink_ready = (sink_cycle % 7) < 4;
        endcase
        rsp_ch.ready <= sink_ready;
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Right after reset the cursor sits at byte 0 with the byte untouched.
    task automatic test_reset_state();
        send_word(REQ_USED, 8'h00, 4'd0);
    endtask

    // Puts of every shape, including a straddle, a zero count and an
    // oversized count, then reads them back from the start. Finally a short
    // put over a full byte shows that the low bits of the byte are cleared.
    task automatic test_put_get();
        send_word(REQ_PUT, 8'hFF, 4'd8);
        send_word(REQ_PUT, 8'h05, 4'd3);
        send_word(REQ_PUT, 8'h7F, 4'd7);
        send_word(REQ_PUT, 8'hAA, 4'd0);
        send_word(REQ_PUT, 8'h3C, 4'd15);
        send_word(REQ_USED, 8'hFF, 4'd8);
        send_word(REQ_REWIND, 8'hFF, 4'd15);
        send_word(REQ_GET, 8'h00, 4'd8);
        send_word(REQ_GET, 8'h00, 4'd3);
        send_word(REQ_GET, 8'h00, 4'd7);
        send_word(REQ_GET, 8'h00, 4'd12);
        send_word(REQ_GET, 8'hFF, 4'd0);
        send_word(REQ_REWIND, 8'h00, 4'd0);
        send_word(REQ_PUT, 8'h01, 4'd1);
        send_word(REQ_REWIND, 8'h00, 4'd0);
        send_word(REQ_GET, 8'h00, 4'd8);
    endtask

    // A zero length refuses everything. A one-byte length accepts a full
    // byte and then refuses the access that would step to the next byte.
    task automatic test_overrun();
        set_buffer_len(11'd0);
        send_word(REQ_PUT, 8'hFF, 4'd1);
        send_word(REQ_GET, 8'h00, 4'd1);
        set_buffer_len(11'd1);
        send_word(REQ_REWIND, 8'h00, 4'd0);
        send_word(REQ_PUT, 8'hC3, 4'd8);
        send_word(REQ_PUT, 8'h01, 4'd1);
        send_word(REQ_REWIND, 8'h00, 4'd0);
        send_word(REQ_GET, 8'h00, 4'd8);
        send_word(REQ_GET, 8'h00, 4'd1);
    endtask

    // Fills the whole store with random bits through a length above the
    // store size, which saturates, until a put past the last byte is refused.
    // Afterwards every entry has been written at least once.
    task automatic test_full_store();
        logic [CNT_W-1:0] cnt;

        set_buffer_len(11'd2047);
        send_word(REQ_REWIND, WBITS_W'($urandom), pick_count());
        do
        begin
            cnt = ($urandom_range(0, 3) != 0) ? 4'd8 : 4'($urandom_range(1, 8));
            send_word(REQ_PUT, WBITS_W'($urandom), cnt);
        end
        while (!last_overrun);
        send_word(REQ_USED, WBITS_W'($urandom), pick_count());
        send_safe(REQ_GET, WBITS_W'($urandom), pick_count());
        send_word(REQ_PUT, WBITS_W'($urandom), 4'd8);
    endtask

    // Write a short record from the start and read it back with the same
    // counts, so the gets land on exactly the bits the puts left.
    task automatic run_readback(input int unsigned k);
        logic [CNT_W-1:0] counts [16];
        int unsigned      i;

        send_safe(REQ_REWIND, WBITS_W'($urandom), pick_count());
        for (i = 0; i < k; i++)
        begin
            counts[i] = pick_count();
            send_safe(REQ_PUT, WBITS_W'($urandom), counts[i]);
        end
        send_safe(REQ_REWIND, WBITS_W'($urandom), pick_count());
        for (i = 0; i < k; i++)
            send_safe(REQ_GET, WBITS_W'($urandom), counts[i]);
    endtask

    // A long run of puts without rewind drives the cursor into the length.
    task automatic run_stream(input int unsigned k);
        int unsigned i;

        for (i = 0; i < k; i++)
            send_safe(REQ_PUT, WBITS_W'($urandom), pick_count());
        send_safe(REQ_USED, WBITS_W'($urandom), pick_count());
    endtask

    task automatic run_noise(input int unsigned k);
        int unsigned i;

        for (i = 0; i < k; i++)
            send_safe(pick_request(), WBITS_W'($urandom), pick_count());
    endtask

    // Random traffic under a series of lengths: the extremes, small lengths
    // that overrun often, and random ones. The cursor is kept across each
    // length change, so it can sit past a length that just shrank.
    task automatic test_random_traffic();
        logic [LEN_W-1:0] lengths [10];
        int unsigned      phase;
        int unsigned      phase_end;
        int unsigned      pick;

        lengths[0] = 11'd1024;
        lengths[1] = 11'd3;
        lengths[2] = 11'd1;
        lengths[3] = 11'd16;
        lengths[4] = 11'd0;
        lengths[5] = 11'd2;
        lengths[6] = LEN_W'($urandom_range(1, 64));
        lengths[7] = 11'd2047;
        lengths[8] = LEN_W'($urandom_range(0, 2047));
        lengths[9] = 11'd1024;
        for (phase = 0; phase < 10; phase++)
        begin
            set_buffer_len(lengths[phase]);
            // Some phases run with a sender that never idles.
            idle_enabled = ($urandom_range(0, 3) != 0);
            phase_end = words_sent + 100;
            while (words_sent < phase_end)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 45)
                    run_readback($urandom_range(1, 12));
                else if (pick < 60)
                    run_stream($urandom_range(8, 40));
                else
                    run_noise($urandom_range(1, 8));
                // Now and then the sender holds until everything is back.
                if ($urandom_range(0, 39) == 0)
                    wait_for_results();
            end
        end
        idle_enabled = 1'b1;
    endtask

    // ------------------------------------------------------------------
    // Sequence of the run
    // ------------------------------------------------------------------

    initial
    begin
        clk             = 1'b0;
        rst_n           = 1'b0;
        cfg_wr_en       = 1'b0;
        cfg_wr_data     = '0;
        req_ch.valid      = 1'b0;
        req_ch.req_type   = REQ_REWIND;
        req_ch.write_bits = '0;
        req_ch.bit_count  = '0;
        rsp_ch.ready      = 1'b0;

        error_count  = 0;
        results_seen = 0;
        words_sent   = 0;
        burst_left   = $urandom_range(1, 16);
        idle_enabled = 1'b1;
        sender_valid = 1'b0;
        last_overrun = 1'b0;
        sink_mode    = SINK_RANDOM;
        sink_cycle   = 0;
        sink_run     = 0;
        sink_ready   = 1'b0;

        // Reset state of the predictor mirrors the block: cursor at byte 0,
        // a fresh byte, length 1024, and nothing in the store written.
        cursor_byte = '0;
        cursor_free = 4'd8;
        length_reg  = LEN_RESET;
        foreach (store_written[i])
            store_written[i] = 1'b0;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_state();
        test_put_get();
        test_overrun();
        test_full_store();
        test_random_traffic();

        // Let the last results drain, then keep the clock running so that any
        // stray word would still be caught.
        wait_for_results();
        repeat (16) @(posedge clk);

        if (error_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

`default_nettype wire

[files.f]
rtl/mbb_pkg.sv
rtl/mbb_interfaces.sv
rtl/mbb_ctrl.sv
rtl/mbb_datapath.sv
rtl/msb_first_bit_buffer.sv
rtl/mbb_checker.sv
bench/msb_first_bit_buffer_tb.sv
